[rtl/fqr_pkg.sv]
// ----------------------------------------------------------------------------
// fqr_pkg
// Shared types, codes and constants of the FIFO queue with rotate.
// ----------------------------------------------------------------------------
package fqr_pkg;

	localparam int DEPTH   = 16;
	localparam int VALUE_W = 32;

	typedef enum logic [1:0] {
		ACT_ENQUEUE = 2'd0,
		ACT_DEQUEUE = 2'd1,
		ACT_ROTATE  = 2'd2,
		ACT_DUMP    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CTL_IDLE = 2'd0,
		CTL_READ = 2'd1,
		CTL_OUT  = 2'd2
	} ctl_state_t;

	typedef struct packed {
		logic enq_write;
		logic res_full;
		logic res_empty;
		logic rd_head;
		logic rd_next;
		logic deq_fin;
		logic rot_fin;
		logic dump_fin;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic res_last;
	} sts_t;

endpackage

[rtl/fqr_req_if.sv]
// ----------------------------------------------------------------------------
// fqr_req_if
// Request channel: one queue operation per transfer.
// ----------------------------------------------------------------------------
interface fqr_req_if;
	logic                                valid;
	logic                                ready;
	fqr_pkg::action_t                    action;
	logic signed [fqr_pkg::VALUE_W-1:0]  push_value;

	modport source (output valid, output action, output push_value, input ready);
	modport sink   (input valid, input action, input push_value, output ready);
endinterface

[rtl/fqr_rsp_if.sv]
// ----------------------------------------------------------------------------
// fqr_rsp_if
// Response channel: one result per transfer, with count, status and last.
// ----------------------------------------------------------------------------
interface fqr_rsp_if #(
	parameter int DEPTH = fqr_pkg::DEPTH
);
	localparam int CW = $clog2(DEPTH + 1);

	logic                                valid;
	logic                                ready;
	logic signed [fqr_pkg::VALUE_W-1:0]  out_value;
	logic [CW-1:0]                       entry_count;
	logic [1:0]                          status;
	logic                                last;

	modport source (output valid, output out_value, output entry_count, output status,
		output last, input ready);
	modport sink   (input valid, input out_value, input entry_count, input status,
		input last, output ready);
endinterface

[rtl/fqr_ctrl.sv]
// ----------------------------------------------------------------------------
// fqr_ctrl
// Controller: sequences each request through accept, a store read where one is needed, and result.
// ----------------------------------------------------------------------------
module fqr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  fqr_pkg::action_t   req_action,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  fqr_pkg::sts_t      sts,
	output fqr_pkg::cmd_t      cmd
);

	fqr_pkg::ctl_state_t state_q;
	fqr_pkg::ctl_state_t state_d;
	fqr_pkg::action_t    op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fqr_pkg::CTL_IDLE;
			op_q    <= fqr_pkg::ACT_ENQUEUE;
		end else begin
			state_q <= state_d;
			if (state_q == fqr_pkg::CTL_IDLE && req_valid) begin
				op_q <= req_action;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fqr_pkg::CTL_IDLE: begin
				if (req_valid) begin
					if (req_action == fqr_pkg::ACT_ENQUEUE || sts.empty) begin
						state_d = fqr_pkg::CTL_OUT;
					end else begin
						state_d = fqr_pkg::CTL_READ;
					end
				end
			end
			fqr_pkg::CTL_READ: state_d = fqr_pkg::CTL_OUT;
			fqr_pkg::CTL_OUT: begin
				if (rsp_ready) begin
					state_d = sts.res_last ? fqr_pkg::CTL_IDLE : fqr_pkg::CTL_READ;
				end
			end
			default: state_d = fqr_pkg::CTL_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		case (state_q)
			fqr_pkg::CTL_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_action == fqr_pkg::ACT_ENQUEUE) begin
						cmd.enq_write = !sts.full;
						cmd.res_full  = sts.full;
					end else if (sts.empty) begin
						cmd.res_empty = 1'b1;
					end else begin
						cmd.rd_head = 1'b1;
					end
				end
			end
			fqr_pkg::CTL_READ: begin
				case (op_q)
					fqr_pkg::ACT_DEQUEUE: cmd.deq_fin  = 1'b1;
					fqr_pkg::ACT_ROTATE:  cmd.rot_fin  = 1'b1;
					fqr_pkg::ACT_DUMP:    cmd.dump_fin = 1'b1;
					default:              cmd          = '0;
				endcase
			end
			fqr_pkg::CTL_OUT: begin
				rsp_valid   = 1'b1;
				cmd.rd_next = rsp_ready && !sts.res_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule

[rtl/fqr_datapath.sv]
// ----------------------------------------------------------------------------
// fqr_datapath
// Datapath: ring store, head/tail indices, occupancy and result register.
// ----------------------------------------------------------------------------
module fqr_datapath #(
	parameter int DEPTH = fqr_pkg::DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fqr_pkg::cmd_t                       cmd,
	output fqr_pkg::sts_t                       sts,
	input  logic signed [fqr_pkg::VALUE_W-1:0]  push_value,
	output logic signed [fqr_pkg::VALUE_W-1:0]  out_value,
	output logic [$clog2(DEPTH+1)-1:0]          entry_count,
	output logic [1:0]                          status,
	output logic                                last
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [fqr_pkg::VALUE_W-1:0] mem [DEPTH];
	logic signed [fqr_pkg::VALUE_W-1:0] rd_data_q;
	logic [IW-1:0]                      head_q;
	logic [IW-1:0]                      tail_q;
	logic [CW-1:0]                      cnt_q;
	logic [IW-1:0]                      ptr_q;
	logic [CW-1:0]                      remain_q;
	logic signed [fqr_pkg::VALUE_W-1:0] val_q;
	logic [CW-1:0]                      res_cnt_q;
	fqr_pkg::status_t                   res_st_q;
	logic                               last_q;

	logic                               wr_en;
	logic signed [fqr_pkg::VALUE_W-1:0] wr_data;
	logic                               rd_en;
	logic [IW-1:0]                      rd_addr;

	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
		return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	assign sts.full     = (cnt_q == CW'(DEPTH));
	assign sts.empty    = (cnt_q == '0);
	assign sts.res_last = last_q;

	assign wr_en   = cmd.enq_write | cmd.rot_fin;
	assign wr_data = cmd.enq_write ? push_value : rd_data_q;
	assign rd_en   = cmd.rd_head | cmd.rd_next;
	assign rd_addr = cmd.rd_head ? head_q : ptr_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			ptr_q     <= nxt(rd_addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.enq_write) begin
				tail_q <= nxt(tail_q);
				cnt_q  <= cnt_q + 1'b1;
			end
			if (cmd.deq_fin) begin
				head_q <= nxt(head_q);
				cnt_q  <= cnt_q - 1'b1;
			end
			if (cmd.rot_fin) begin
				head_q <= nxt(head_q);
				tail_q <= nxt(tail_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_head) begin
			remain_q <= cnt_q;
		end
		if (cmd.enq_write) begin
			val_q     <= '0;
			res_cnt_q <= cnt_q + 1'b1;
			res_st_q  <= fqr_pkg::STAT_OK;
			last_q    <= 1'b1;
		end
		if (cmd.res_full) begin
			val_q     <= '0;
			res_cnt_q <= cnt_q;
			res_st_q  <= fqr_pkg::STAT_FULL;
			last_q    <= 1'b1;
		end
		if (cmd.res_empty) begin
			val_q     <= '0;
			res_cnt_q <= '0;
			res_st_q  <= fqr_pkg::STAT_EMPTY;
			last_q    <= 1'b1;
		end
		if (cmd.deq_fin) begin
			val_q     <= rd_data_q;
			res_cnt_q <= cnt_q - 1'b1;
			res_st_q  <= fqr_pkg::STAT_OK;
			last_q    <= 1'b1;
		end
		if (cmd.rot_fin) begin
			val_q     <= '0;
			res_cnt_q <= cnt_q;
			res_st_q  <= fqr_pkg::STAT_OK;
			last_q    <= 1'b1;
		end
		if (cmd.dump_fin) begin
			val_q     <= rd_data_q;
			res_cnt_q <= cnt_q;
			res_st_q  <= fqr_pkg::STAT_OK;
			last_q    <= (remain_q == CW'(1));
			remain_q  <= remain_q - 1'b1;
		end
	end

	assign out_value   = val_q;
	assign entry_count = res_cnt_q;
	assign status      = res_st_q;
	assign last        = last_q;

endmodule

[rtl/fifo_queue_with_rotate_unit.sv]
// Results: enqueue and error results are registered and valid in the cycle after the request transfer;
// dequeue and rotate results pass a registered store read before the result register.
// Throughput: one request at a time; the next request is taken the cycle after the
// final result transfer. A dump gives its entries one by one (read, then result).
// Reset: head, tail and count clear at once; store contents stay undefined.
// ----------------------------------------------------------------------------
// fifo_queue_with_rotate_unit
// Bounded FIFO queue of signed values with enqueue, dequeue, rotate and dump.
// ----------------------------------------------------------------------------
module fifo_queue_with_rotate_unit #(
	parameter int DEPTH = fqr_pkg::DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	fqr_req_if.sink    req,
	fqr_rsp_if.source  rsp
);

	fqr_pkg::cmd_t cmd;
	fqr_pkg::sts_t sts;

	fqr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	fqr_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.push_value  (req.push_value),
		.out_value   (rsp.out_value),
		.entry_count (rsp.entry_count),
		.status      (rsp.status),
		.last        (rsp.last)
	);

endmodule

[tb/fqr_queue_checker.sv]
// ----------------------------------------------------------------------------
// fqr_queue_checker
// Watches the request and response channels of the FIFO queue with rotate.
// Keeps its own ring store, head, tail and count. Every request transfer yields
// the responses it should cause, and these are compared field by field, in order,
// with the response transfers.
// ----------------------------------------------------------------------------
module fqr_queue_checker #(
	parameter int DEPTH = fqr_pkg::DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	fqr_req_if   req,
	fqr_rsp_if   rsp,
	output int   fail_count,
	output int   due_count
);
	import fqr_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [CW-1:0]             count;
		status_t                   status;
		logic                      last;
	} queue_result_t;

	logic signed [VALUE_W-1:0] ring [DEPTH];
	int                        ring_head = 0;
	int                        ring_tail = 0;
	int                        ring_count = 0;
	int                        errors = 0;
	queue_result_t             due_results [$];

	assign fail_count = errors;

	function automatic void apply_queue_op(action_t act, logic signed [VALUE_W-1:0] v);
		queue_result_t r;
		r.value  = '0;
		r.status = STAT_OK;
		r.last   = 1'b1;
		if (act == ACT_ENQUEUE) begin
			if (ring_count >= DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				ring[ring_tail] = v;
				ring_tail = (ring_tail + 1) % DEPTH;
				ring_count++;
			end
		end else if (ring_count == 0) begin
			r.status = STAT_EMPTY;
		end else if (act == ACT_DEQUEUE) begin
			r.value = ring[ring_head];
			ring_head = (ring_head + 1) % DEPTH;
			ring_count--;
		end else if (act == ACT_ROTATE) begin
			ring[ring_tail] = ring[ring_head];
			ring_head = (ring_head + 1) % DEPTH;
			ring_tail = (ring_tail + 1) % DEPTH;
		end else begin
			for (int i = 0; i < ring_count; i++) begin
				r.value = ring[(ring_head + i) % DEPTH];
				r.count = CW'(ring_count);
				r.last  = (i == ring_count - 1);
				due_results.push_back(r);
			end
			return;
		end
		r.count = CW'(ring_count);
		due_results.push_back(r);
	endfunction

	task automatic check_result();
		queue_result_t want;
		if (due_results.size() == 0) begin
			$display("%0t: unexpected result: expected none, got value %0d count %0d status %0d last %0b",
				$time, rsp.out_value, rsp.entry_count, rsp.status, rsp.last);
			errors++;
		end else begin
			want = due_results.pop_front();
			if (rsp.out_value !== want.value) begin
				$display("%0t: out_value mismatch: expected %0d, got %0d",
					$time, want.value, rsp.out_value);
				errors++;
			end
			if (rsp.entry_count !== want.count) begin
				$display("%0t: entry_count mismatch: expected %0d, got %0d",
					$time, want.count, rsp.entry_count);
				errors++;
			end
			if (rsp.status !== want.status) begin
				$display("%0t: status mismatch: expected %0d, got %0d",
					$time, want.status, rsp.status);
				errors++;
			end
			if (rsp.last !== want.last) begin
				$display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, rsp.last);
				errors++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_head  = 0;
			ring_tail  = 0;
			ring_count = 0;
			due_results.delete();
			due_count <= 0;
		end else begin
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				check_result();
			end
			if (req.valid === 1'b1 && req.ready === 1'b1) begin
				apply_queue_op(req.action, req.push_value);
			end
			due_count <= due_results.size();
		end
	end

endmodule

[tb/fifo_queue_with_rotate_unit_tb.sv]
// ----------------------------------------------------------------------------
// fifo_queue_with_rotate_unit_tb
// Drives queue requests into the FIFO queue with rotate: a directed pass over
// empty, full, rotate-when-full and dump cases, then random fill and drain
// phases with random idling on both channels, a quiet stretch and long response
// hold-offs. A checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module fifo_queue_with_rotate_unit_tb;
	import fqr_pkg::*;

	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_OPS     = 200;
	localparam int DRAIN_CYCLES   = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic quiet = 1'b0;
	int   fail_count;
	int   due_count;
	int   holds_asked = 0;
	int   holds_done = 0;
	int   stuck_cycles = 0;

	fqr_req_if                  req_ch ();
	fqr_rsp_if #(.DEPTH(DEPTH)) rsp_ch ();

	fifo_queue_with_rotate_unit #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	fqr_queue_checker #(.DEPTH(DEPTH)) queue_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.due_count  (due_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
			(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// response side: random stalls, long hold-offs on request
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done < holds_asked) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else begin
				rsp_ch.ready <= arst_n && (quiet || $urandom_range(99) >= 24);
			end
		end
	end

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return {1'b1, {(VALUE_W-1){1'b0}}};
			1: return {1'b0, {(VALUE_W-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_op(action_t act, logic signed [VALUE_W-1:0] v);
		while (!quiet && $urandom_range(99) < 24) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.action     <= act;
		req_ch.push_value <= v;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
	endtask

	initial begin
		int      fill_bias;
		int      roll;
		action_t act;

		req_ch.valid      <= 1'b0;
		req_ch.action     <= ACT_ENQUEUE;
		req_ch.push_value <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue errors
		send_op(ACT_DEQUEUE, 32'sd5);
		send_op(ACT_ROTATE, -32'sd1);
		send_op(ACT_DUMP, 32'sd0);
		// fill with extremes and bit patterns
		for (int i = 0; i < DEPTH; i++) begin
			case (i)
				0: send_op(ACT_ENQUEUE, {1'b1, {(VALUE_W-1){1'b0}}});
				1: send_op(ACT_ENQUEUE, {1'b0, {(VALUE_W-1){1'b1}}});
				2: send_op(ACT_ENQUEUE, '0);
				3: send_op(ACT_ENQUEUE, '1);
				4: send_op(ACT_ENQUEUE, 32'h5555_5555);
				5: send_op(ACT_ENQUEUE, 32'haaaa_aaaa);
				default: send_op(ACT_ENQUEUE, $urandom);
			endcase
		end
		send_op(ACT_ENQUEUE, 32'sd77);
		send_op(ACT_ROTATE, 32'sd0);
		send_op(ACT_DUMP, 32'sd0);
		send_op(ACT_DEQUEUE, 32'sd0);
		send_op(ACT_DUMP, 32'sd0);

		for (int n = 0; n < RANDOM_OPS; n++) begin
			fill_bias = ((n / 25) % 2 == 0) ? 70 : 25;
			quiet = (n >= 90 && n < 140);
			if (n == 60 || n == 170) begin
				holds_asked++;
			end
			roll = $urandom_range(99);
			if (roll < fill_bias) begin
				act = ACT_ENQUEUE;
			end else begin
				roll = $urandom_range(99);
				act = (roll < 55) ? ACT_DEQUEUE : (roll < 80) ? ACT_ROTATE : ACT_DUMP;
			end
			send_op(act, pick_value());
		end
		quiet = 1'b0;
		req_ch.valid <= 1'b0;

		// let the checker count the results of the final transfer
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && due_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
